// File: hdl/text_terminal_writer_defines.svh
// Assertion helpers used by the terminal writer control unit.
`ifndef TEXT_TERMINAL_WRITER_DEFINES_SVH
`define TEXT_TERMINAL_WRITER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TTW_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define TTW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/ttw_pkg.sv
package ttw_pkg;

   // Default screen geometry
   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   // Cell layout: attribute in the high byte, character in the low byte
   localparam int CELL_DATA_W = 16;

   // Control characters and the blank fill character
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_BACKSPACE = 8'h08;

   // Register file
   localparam int         CSR_ADDR_W          = 3;
   localparam int         CSR_DATA_W          = 32;
   localparam logic       REG_BLANK_ATTRIBUTE = 1'b0;
   localparam logic [7:0] BLANK_ATTR_RESET    = 8'd15;

   // Item operations
   typedef enum logic [1:0] {
      OP_PRINT = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   // Result item
   typedef struct packed {
      logic [10:0] cursor_cell;
      logic [7:0]  read_char;
      logic [7:0]  read_attr;
      logic        scrolled;
   } rsp_type;

endpackage

// File: hdl/ttw_ram.sv
module ttw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// File: hdl/ttw_csr.sv
module ttw_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ttw_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ttw_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ttw_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output logic [7:0]                     blank_attribute
);

   logic       reg_idx;
   logic       wr_en;
   logic [7:0] blank_attr_ff;
   logic [7:0] blank_attr_in;

   // Decode the word index and the access phase of a write
   assign reg_idx = paddr[2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      blank_attr_in = blank_attr_ff;
      if (wr_en && (reg_idx == ttw_pkg::REG_BLANK_ATTRIBUTE)) begin
         blank_attr_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blank_attr_ff <= ttw_pkg::BLANK_ATTR_RESET;
      end else begin
         blank_attr_ff <= blank_attr_in;
      end
   end

   // Return the register value, zero beyond the register list
   always_comb begin
      prdata = '0;
      if (reg_idx == ttw_pkg::REG_BLANK_ATTRIBUTE) begin
         prdata = {{(ttw_pkg::CSR_DATA_W - 8){1'b0}}, blank_attr_ff};
      end
   end

   assign blank_attribute = blank_attr_ff;

endmodule

// File: hdl/ttw_ctrl.sv
`include "text_terminal_writer_defines.svh"

module ttw_ctrl #(
   parameter int COLUMNS = ttw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = ttw_pkg::ROWS_DEFAULT,
   localparam int CELLS  = COLUMNS * ROWS,
   localparam int CELL_W = $clog2(CELLS)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_operation,
   input  logic [7:0]                      req_char_code,
   input  logic [7:0]                      req_attribute,
   input  logic                            req_at_cursor,
   input  logic [10:0]                     req_position,
   input  logic [7:0]                      blank_attribute,
   output logic                            mem_we,
   output logic [CELL_W-1:0]               mem_waddr,
   output logic [ttw_pkg::CELL_DATA_W-1:0] mem_wdata,
   output logic [CELL_W-1:0]               mem_raddr,
   input  logic [ttw_pkg::CELL_DATA_W-1:0] mem_rdata,
   output logic                            rsp_valid,
   output ttw_pkg::rsp_type                rsp
);

   localparam int T_W   = $clog2(CELLS + 1);
   localparam int EXT_W = CELL_W + 11;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_NEWLINE,
      ST_COPY,
      ST_FILL
   } state_type;

   state_type        state_ff, state_in;
   ttw_pkg::op_type  op_ff, op_in;
   logic [7:0]       char_ff, char_in;
   logic [7:0]       attr_ff, attr_in;
   logic [CELL_W-1:0] tgt_ff, tgt_in;
   logic [CELL_W-1:0] cursor_ff, cursor_in;
   logic [T_W-1:0]   cnt_ff, cnt_in;
   logic             pend_ff, pend_in;
   logic             scroll_ff, scroll_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ttw_pkg::rsp_type rsp_ff, rsp_in;

   logic              accept;
   logic [EXT_W-1:0]  pos_ext;
   logic [CELL_W-1:0] pick_pos;
   logic [CELL_W-1:0] pick;
   logic              fin_req;
   logic [T_W-1:0]    fin_t;
   logic [T_W-1:0]    fin_sub;
   logic [T_W-1:0]    copy_dst;
   logic              rd_issue;
   logic              emit;
   logic [7:0]        emit_char;
   logic [7:0]        emit_attr;
   logic              emit_scrolled;
   logic [EXT_W-1:0]  cur_ext;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // Saturate a given position to the last cell, else take the cursor
   always_comb begin
      pos_ext = EXT_W'(req_position);
      if (pos_ext >= EXT_W'(CELLS - 1)) begin
         pick_pos = CELL_W'(CELLS - 1);
      end else begin
         pick_pos = pos_ext[CELL_W-1:0];
      end
      pick = req_at_cursor ? cursor_ff : pick_pos;
   end

   assign fin_sub  = fin_t - T_W'(COLUMNS);
   assign copy_dst = cnt_ff - T_W'(COLUMNS + 1);
   assign rd_issue = (cnt_ff < T_W'(CELLS));

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      char_in       = char_ff;
      attr_in       = attr_ff;
      tgt_in        = tgt_ff;
      cursor_in     = cursor_ff;
      cnt_in        = cnt_ff;
      pend_in       = pend_ff;
      scroll_in     = scroll_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = tgt_ff;
      mem_wdata     = {attr_ff, char_ff};
      mem_raddr     = pick;
      fin_req       = 1'b0;
      fin_t         = '0;
      emit          = 1'b0;
      emit_char     = '0;
      emit_attr     = '0;
      emit_scrolled = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            // Look up the target cell early so a read has its data next cycle
            mem_raddr = pick;
            if (accept) begin
               op_in    = ttw_pkg::op_type'(req_operation);
               char_in  = req_char_code;
               attr_in  = req_attribute;
               tgt_in   = pick;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (op_ff)
               ttw_pkg::OP_PRINT: begin
                  if (char_ff == ttw_pkg::CH_NEWLINE) begin
                     cnt_in   = T_W'(COLUMNS);
                     state_in = ST_NEWLINE;
                  end else if (char_ff == ttw_pkg::CH_BACKSPACE) begin
                     fin_req = 1'b1;
                     fin_t   = (tgt_ff == '0) ? '0 : T_W'(tgt_ff) - T_W'(1);
                  end else begin
                     mem_we  = 1'b1;
                     fin_req = 1'b1;
                     fin_t   = T_W'(tgt_ff) + T_W'(1);
                  end
               end
               ttw_pkg::OP_READ: begin
                  emit      = 1'b1;
                  emit_char = mem_rdata[7:0];
                  emit_attr = mem_rdata[15:8];
               end
               ttw_pkg::OP_CLEAR: begin
                  cursor_in = '0;
                  cnt_in    = '0;
                  scroll_in = 1'b0;
                  state_in  = ST_FILL;
               end
               default: begin
                  emit = 1'b1;
               end
            endcase
         end
         ST_NEWLINE: begin
            // Step row starts until one lies past the target
            if (cnt_ff > T_W'(tgt_ff)) begin
               fin_req = 1'b1;
               fin_t   = cnt_ff;
            end else begin
               cnt_in = cnt_ff + T_W'(COLUMNS);
            end
         end
         ST_COPY: begin
            // Read one row ahead, write back the cell read last cycle
            if (rd_issue) begin
               mem_raddr = cnt_ff[CELL_W-1:0];
               cnt_in    = cnt_ff + T_W'(1);
               pend_in   = 1'b1;
            end else begin
               pend_in  = 1'b0;
               cnt_in   = T_W'(CELLS - COLUMNS);
               state_in = ST_FILL;
            end
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = copy_dst[CELL_W-1:0];
               mem_wdata = mem_rdata;
            end
         end
         ST_FILL: begin
            // Blank one cell per cycle up to the last cell
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[CELL_W-1:0];
            mem_wdata = {blank_attribute, ttw_pkg::CH_SPACE};
            if (cnt_ff == T_W'(CELLS - 1)) begin
               emit          = 1'b1;
               emit_scrolled = scroll_ff;
            end else begin
               cnt_in = cnt_ff + T_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Commit the new cursor; start the scroll when it ran off the screen
      if (fin_req) begin
         if (fin_t >= T_W'(CELLS)) begin
            cursor_in = fin_sub[CELL_W-1:0];
            cnt_in    = T_W'(COLUMNS);
            pend_in   = 1'b0;
            scroll_in = 1'b1;
            state_in  = ST_COPY;
         end else begin
            cursor_in = fin_t[CELL_W-1:0];
            emit      = 1'b1;
         end
      end

      // Deliver the result item
      cur_ext = EXT_W'(cursor_in);
      if (emit) begin
         rsp_valid_in       = 1'b1;
         state_in           = ST_IDLE;
         rsp_in.cursor_cell = cur_ext[10:0];
         rsp_in.read_char   = emit_char;
         rsp_in.read_attr   = emit_attr;
         rsp_in.scrolled    = emit_scrolled;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         scroll_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         scroll_ff    <= scroll_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff        <= op_in;
         char_ff      <= char_in;
         attr_ff      <= attr_in;
         tgt_ff       <= tgt_in;
         rsp_ff       <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `TTW_ASSERT_NEXT(a_strobe_single, rsp_valid_ff, !rsp_valid_ff, "result strobe held twice")
   `TTW_ASSERT_SAME(a_strobe_idle, rsp_valid_ff, state_ff == ST_IDLE, "result while busy")
   `TTW_ASSERT_NEXT(a_accept_exec, accept, state_ff == ST_EXEC, "accepted item not executed")
   `TTW_ASSERT_SAME(a_cursor_range, 1'b1, T_W'(cursor_ff) < T_W'(CELLS), "cursor off screen")
   `TTW_ASSERT_SAME(a_waddr_range, mem_we, T_W'(mem_waddr) < T_W'(CELLS), "write off screen")

endmodule

// File: hdl/text_terminal_writer.sv
// Text terminal writer: a COLUMNS x ROWS screen of 16-bit cells (attribute
// high byte, character low byte) in one synchronous RAM, plus a cursor.
// Items: raise start with req_* valid; the item is taken on the edge where
// start is high and busy is low. Every item yields one result, shown on
// rsp_* for exactly one cycle with rsp_valid high; the receiver cannot stall
// and must take it then. The next item can be taken during that cycle.
// From acceptance to result: read, plain print, backspace and an unused
// code execute and give the result; a newline first steps row starts, one
// per cycle; a print that scrolls then moves the rows up by one row, one
// cell moved per cycle through the single RAM port pair, and blanks the
// last row; clear blanks every cell, one cell blanked per cycle.
// The register blank_attribute (offset 0) is written over psel/penable with
// pready always high; write it only while the block is idle.
// Reset homes the cursor and sets blank_attribute to 15; the screen RAM is
// not swept, so its cells hold no defined value until cleared or written.
module text_terminal_writer #(
   parameter int COLUMNS = ttw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = ttw_pkg::ROWS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_operation,
   input  logic [7:0]                     req_char_code,
   input  logic [7:0]                     req_attribute,
   input  logic                           req_at_cursor,
   input  logic [10:0]                    req_position,
   output logic                           rsp_valid,
   output logic [10:0]                    rsp_cursor_cell,
   output logic [7:0]                     rsp_read_char,
   output logic [7:0]                     rsp_read_attr,
   output logic                           rsp_scrolled,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ttw_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ttw_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ttw_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int CELL_W = $clog2(CELLS);

   logic [7:0]                      blank_attribute;
   logic                            mem_we;
   logic [CELL_W-1:0]               mem_waddr;
   logic [ttw_pkg::CELL_DATA_W-1:0] mem_wdata;
   logic [CELL_W-1:0]               mem_raddr;
   logic [ttw_pkg::CELL_DATA_W-1:0] mem_rdata;
   ttw_pkg::rsp_type                rsp;

   ttw_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .blank_attribute (blank_attribute)
   );

   ttw_ctrl #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_char_code   (req_char_code),
      .req_attribute   (req_attribute),
      .req_at_cursor   (req_at_cursor),
      .req_position    (req_position),
      .blank_attribute (blank_attribute),
      .mem_we          (mem_we),
      .mem_waddr       (mem_waddr),
      .mem_wdata       (mem_wdata),
      .mem_raddr       (mem_raddr),
      .mem_rdata       (mem_rdata),
      .rsp_valid       (rsp_valid),
      .rsp             (rsp)
   );

   ttw_ram #(
      .WIDTH (ttw_pkg::CELL_DATA_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // Break out the result item
   assign rsp_cursor_cell = rsp.cursor_cell;
   assign rsp_read_char   = rsp.read_char;
   assign rsp_read_attr   = rsp.read_attr;
   assign rsp_scrolled    = rsp.scrolled;

endmodule
